/* design/sei_pkg.sv */
// Shared types, constants and the byte-wide CRC function for the envelope inspector.
package sei_pkg;

    localparam int unsigned HdrLen    = 16;
    localparam int unsigned FtrLen    = 4;
    localparam int unsigned QueueDepth = 2;

    localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
    localparam logic [31:0] MagicLegacy = {8'h50, 8'h4C, 8'h55, 8'h50}; // bytes 3..0
    localparam logic [31:0] MagicEnv    = {8'h54, 8'h53, 8'h4C, 8'h50};
    localparam logic [31:0] CurVersion  = 32'd1;

    typedef enum logic [2:0] {
        CFG_MAX_TOTAL  = 3'd0,
        CFG_MAX_STORE  = 3'd1,
        CFG_MAX_PLUGIN = 3'd2,
        CFG_LARGE_THR  = 3'd3,
        CFG_MIG_READY  = 3'd4
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_EMPTY       = 4'd1,
        ST_UNKNOWN     = 4'd2,
        ST_TRUNCATED   = 4'd3,
        ST_BAD_VERSION = 4'd4,
        ST_NO_MIGRATE  = 4'd5,
        ST_SIZE        = 4'd6,
        ST_CRC         = 4'd7,
        ST_EMPTY_STORE = 4'd8,
        ST_TOTAL_BUDGET  = 4'd9,
        ST_STORE_BUDGET  = 4'd10,
        ST_PLUGIN_BUDGET = 4'd11
    } t_status;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_LEGACY  = 2'd1,
        FMT_ENV     = 2'd2
    } t_format;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       blob_empty;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  format;
        logic [31:0] total_len;
        logic [31:0] store_size;
        logic [31:0] plugin_size;
        logic [31:0] version_seen;
        logic        needs_migration;
        logic        large_blob;
        logic        needs_plugin_restore;
        logic        may_need_relink;
    } t_out_item;

    typedef struct packed {
        logic [31:0] max_total;
        logic [31:0] max_store;
        logic [31:0] max_plugin;
        logic [31:0] large_thr;
        logic        mig_ready;
    } t_cfg;

    // What the front hands to the back for one finished blob.
    typedef struct packed {
        logic        empty;
        logic        legacy;
        logic        env;
        logic [31:0] total;
        logic [31:0] version;
        logic [31:0] store;
        logic [31:0] plugin;
        logic [31:0] tail;
        logic [31:0] crc;
    } t_summary;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* design/sei_front.sv */
// Front part: byte count, header capture, tail delay line and running CRC.
module sei_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  sei_pkg::t_in_item   i_item,
    output logic                o_push,
    output sei_pkg::t_summary   o_summary
);

    logic [31:0] r_count, n_count;
    logic [7:0]  r_hdr [sei_pkg::HdrLen];
    logic [7:0]  n_hdr [sei_pkg::HdrLen];
    logic [7:0]  r_tail [sei_pkg::FtrLen];
    logic [7:0]  n_tail [sei_pkg::FtrLen];
    logic [31:0] r_crc, n_crc;
    logic        clear;
    logic [31:0] magic;

    always_comb begin
        n_count = r_count;
        n_hdr   = r_hdr;
        n_tail  = r_tail;
        n_crc   = r_crc;
        if (r_count >= 32'(sei_pkg::FtrLen)) begin
            n_crc = sei_pkg::crc_byte(r_crc, r_tail[0]);
        end
        for (int i = 0; i < int'(sei_pkg::FtrLen) - 1; i++) begin
            n_tail[i] = r_tail[i + 1];
        end
        n_tail[sei_pkg::FtrLen - 1] = i_item.data_byte;
        if (r_count < 32'(sei_pkg::HdrLen)) begin
            n_hdr[r_count[3:0]] = i_item.data_byte;
        end
        if (r_count != 32'hFFFF_FFFF) begin
            n_count = r_count + 32'd1;
        end
    end

    assign magic  = {n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0]};
    assign clear  = i_accept && (i_item.blob_empty || i_item.last_byte);
    assign o_push = clear;

    always_comb begin
        o_summary.empty   = i_item.blob_empty;
        o_summary.legacy  = (n_count >= 32'd4) && (magic == sei_pkg::MagicLegacy);
        o_summary.env     = (n_count >= 32'd4) && (magic == sei_pkg::MagicEnv);
        o_summary.total   = n_count;
        o_summary.version = {n_hdr[7], n_hdr[6], n_hdr[5], n_hdr[4]};
        o_summary.store   = {n_hdr[11], n_hdr[10], n_hdr[9], n_hdr[8]};
        o_summary.plugin  = {n_hdr[15], n_hdr[14], n_hdr[13], n_hdr[12]};
        o_summary.tail    = {n_tail[3], n_tail[2], n_tail[1], n_tail[0]};
        o_summary.crc     = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_count <= '0;
            r_crc   <= sei_pkg::CrcInit;
            for (int i = 0; i < int'(sei_pkg::HdrLen); i++) r_hdr[i] <= '0;
            for (int i = 0; i < int'(sei_pkg::FtrLen); i++) r_tail[i] <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_hdr   <= n_hdr;
            r_tail  <= n_tail;
        end
    end

endmodule

/* design/sei_queue.sv */
// Two-entry queue of blob summaries between the front and the back.
module sei_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  sei_pkg::t_summary       i_data,
    input  logic                    i_pop,
    output sei_pkg::t_summary       o_data,
    output sei_pkg::t_queue_status  o_status
);

    sei_pkg::t_summary r_mem [sei_pkg::QueueDepth];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == 2'(sei_pkg::QueueDepth));
    assign o_status.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* design/sei_back.sv */
// Back part: runs the checks on one blob summary and holds the result item.
module sei_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sei_pkg::t_cfg       i_cfg,
    input  logic                i_have,
    input  sei_pkg::t_summary   i_summary,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output sei_pkg::t_out_item  o_item
);

    logic               r_valid;
    sei_pkg::t_out_item r_item;
    sei_pkg::t_out_item res;
    sei_pkg::t_status   st;
    sei_pkg::t_format   fmt;
    logic [33:0]        expect_len;
    logic               over_total, over_store, over_plugin;

    assign expect_len = 34'(sei_pkg::HdrLen + sei_pkg::FtrLen)
                      + {2'b00, i_summary.store} + {2'b00, i_summary.plugin};

    always_comb begin
        res         = '0;
        res.total_len  = i_summary.total;
        res.large_blob = (i_cfg.large_thr != '0) && (i_summary.total > i_cfg.large_thr);
        fmt         = sei_pkg::FMT_UNKNOWN;
        st          = sei_pkg::ST_OK;
        over_total  = (i_cfg.max_total != '0) && (i_summary.total > i_cfg.max_total);
        over_store  = 1'b0;
        over_plugin = 1'b0;
        if (over_total) begin
            st = sei_pkg::ST_TOTAL_BUDGET;
        end else if (i_summary.legacy) begin
            fmt            = sei_pkg::FMT_LEGACY;
            res.store_size = i_summary.total;
            over_store = (i_cfg.max_store != '0) && (i_summary.total > i_cfg.max_store);
            st = over_store ? sei_pkg::ST_STORE_BUDGET : sei_pkg::ST_OK;
        end else if (!i_summary.env) begin
            st = sei_pkg::ST_UNKNOWN;
        end else begin
            fmt = sei_pkg::FMT_ENV;
            if (i_summary.total < 32'(sei_pkg::HdrLen + sei_pkg::FtrLen)) begin
                st = sei_pkg::ST_TRUNCATED;
            end else begin
                res.version_seen    = i_summary.version;
                res.needs_migration = (i_summary.version < sei_pkg::CurVersion);
                if (i_summary.version > sei_pkg::CurVersion) begin
                    st = sei_pkg::ST_BAD_VERSION;
                end else if ({2'b00, i_summary.total} != expect_len) begin
                    st = sei_pkg::ST_SIZE;
                end else begin
                    res.store_size           = i_summary.store;
                    res.plugin_size          = i_summary.plugin;
                    res.needs_plugin_restore = (i_summary.plugin != '0);
                    res.may_need_relink      = (i_summary.plugin != '0);
                    over_store  = (i_cfg.max_store != '0)
                               && (i_summary.store > i_cfg.max_store);
                    over_plugin = (i_cfg.max_plugin != '0)
                               && (i_summary.plugin > i_cfg.max_plugin);
                    if (i_summary.tail != ~i_summary.crc) begin
                        st = sei_pkg::ST_CRC;
                    end else if (i_summary.store == '0) begin
                        st = sei_pkg::ST_EMPTY_STORE;
                    end else if (res.needs_migration && !i_cfg.mig_ready) begin
                        st = sei_pkg::ST_NO_MIGRATE;
                    end else if (over_store) begin
                        st = sei_pkg::ST_STORE_BUDGET;
                    end else if (over_plugin) begin
                        st = sei_pkg::ST_PLUGIN_BUDGET;
                    end else begin
                        st = sei_pkg::ST_OK;
                    end
                end
            end
        end
        res.status = st;
        res.format = fmt;
        if (i_summary.empty) begin
            res        = '0;
            res.status = sei_pkg::ST_EMPTY;
        end
    end

    assign o_pop   = i_have && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= res;
        end
    end

endmodule

/* design/state_envelope_inspector.sv */
// Top level of the state envelope inspector: config registers, front, queue and back.
//
// Usage: one blob byte enters per item on the input channel (i_in_valid,
// o_in_stall, i_in_item); the item marked last_byte, or any item marked
// blob_empty, produces one result item on the output channel (o_out_valid,
// i_out_stall, o_out_item). Other items produce nothing.
// Throughput is one byte per cycle while o_in_stall is low: the front folds
// each byte into the count, header, tail line and a byte-wide CRC.
// The closing item's summary is written into the two-entry summary queue,
// then checked by the back and captured in the output register.
// When the receiver stalls, the result register holds; the queue absorbs two
// more finished blobs, after which o_in_stall rises until space frees.
// Configuration registers are written through i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data; ready is always high and writes to unknown
// indexes are ignored. Write them only while the block is idle.
// Reset clears all configuration to zero and starts a fresh blob.
module state_envelope_inspector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sei_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sei_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    sei_pkg::t_cfg           r_cfg;
    sei_pkg::t_summary       front_sum, queue_sum;
    sei_pkg::t_queue_status  q_status;
    logic                    accept, push, pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_status.full;
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sei_pkg::CFG_MAX_TOTAL:  r_cfg.max_total  <= i_cfg_data;
                sei_pkg::CFG_MAX_STORE:  r_cfg.max_store  <= i_cfg_data;
                sei_pkg::CFG_MAX_PLUGIN: r_cfg.max_plugin <= i_cfg_data;
                sei_pkg::CFG_LARGE_THR:  r_cfg.large_thr  <= i_cfg_data;
                sei_pkg::CFG_MIG_READY:  r_cfg.mig_ready  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sei_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_item),
        .o_push    (push),
        .o_summary (front_sum)
    );

    sei_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_sum),
        .i_pop    (pop),
        .o_data   (queue_sum),
        .o_status (q_status)
    );

    sei_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_have    (!q_status.empty),
        .i_summary (queue_sum),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

`ifndef SYNTHESIS
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("back popped an empty queue");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == sei_pkg::ST_EMPTY) |->
        (o_out_item.format == sei_pkg::FMT_UNKNOWN && o_out_item.total_len == '0))
        else $error("empty result carries data");

    a_legacy_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.format == sei_pkg::FMT_LEGACY) |->
        (o_out_item.store_size == o_out_item.total_len))
        else $error("legacy result store size differs from total");
`endif

endmodule

/* verif/state_envelope_inspector_tb.sv */
// Self-checking testbench for the state envelope inspector: blob streams against a predictor.
`timescale 1ns / 100ps

module state_envelope_inspector_tb;

    typedef enum int {
        BK_EMPTY, BK_LEGACY, BK_ENV, BK_BAD_CRC, BK_SIZE, BK_TRUNC,
        BK_NOISE, BK_EMPTY_MID, BK_BOTH
    } t_blob_kind;

    typedef struct {
        t_blob_kind        kind;
        int unsigned       store_len;
        int unsigned       plugin_len;
        logic [31:0]       version;
        bit                has_status;
        sei_pkg::t_status  status;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    sei_pkg::t_in_item   i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    sei_pkg::t_out_item  o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    // Shadow configuration and stream state of the predictor.
    logic [31:0] budget_total, budget_store, budget_plugin, large_limit;
    logic        zero_mig_ready;
    logic [31:0] seen_count;
    logic [7:0]  seen_header [16];
    logic [7:0]  tail_line [4];
    logic [31:0] crc_acc;

    sei_pkg::t_out_item expected_reports [$];
    sei_pkg::t_in_item  blob_items [$];
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned blobs_sent;
    int unsigned cycle_count = 0;
    bit          no_idle;
    bit          hold_request;

    state_envelope_inspector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] crc_fold(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ sei_pkg::CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void clear_blob();
        seen_count = '0;
        crc_acc = sei_pkg::CrcInit;
        for (int i = 0; i < 16; i++) seen_header[i] = '0;
        for (int i = 0; i < 4; i++) tail_line[i] = '0;
    endfunction

    function automatic sei_pkg::t_status budget_check(input logic [31:0] total,
                                                      input logic [31:0] store,
                                                      input logic [31:0] plugin);
        if (budget_total != 0 && total > budget_total) return sei_pkg::ST_TOTAL_BUDGET;
        if (budget_store != 0 && store > budget_store) return sei_pkg::ST_STORE_BUDGET;
        if (budget_plugin != 0 && plugin > budget_plugin) return sei_pkg::ST_PLUGIN_BUDGET;
        return sei_pkg::ST_OK;
    endfunction

    function automatic sei_pkg::t_out_item diagnose_blob();
        sei_pkg::t_out_item r;
        sei_pkg::t_status   st;
        logic [31:0] magic, ssize, psize, tail;
        logic [33:0] want_len;
        r = '0;
        r.total_len = seen_count;
        r.large_blob = (large_limit != 0) && (seen_count > large_limit);
        magic = {seen_header[3], seen_header[2], seen_header[1], seen_header[0]};
        if (budget_total != 0 && seen_count > budget_total) begin
            st = sei_pkg::ST_TOTAL_BUDGET;
        end else if (seen_count >= 4 && magic == sei_pkg::MagicLegacy) begin
            r.format = sei_pkg::FMT_LEGACY;
            r.store_size = seen_count;
            st = budget_check(seen_count, seen_count, '0);
        end else if (!(seen_count >= 4 && magic == sei_pkg::MagicEnv)) begin
            st = sei_pkg::ST_UNKNOWN;
        end else begin
            r.format = sei_pkg::FMT_ENV;
            if (seen_count < sei_pkg::HdrLen + sei_pkg::FtrLen) begin
                st = sei_pkg::ST_TRUNCATED;
            end else begin
                r.version_seen = {seen_header[7], seen_header[6], seen_header[5], seen_header[4]};
                r.needs_migration = (r.version_seen < sei_pkg::CurVersion);
                ssize = {seen_header[11], seen_header[10], seen_header[9], seen_header[8]};
                psize = {seen_header[15], seen_header[14], seen_header[13], seen_header[12]};
                want_len = 34'(sei_pkg::HdrLen + sei_pkg::FtrLen) + 34'(ssize) + 34'(psize);
                if (r.version_seen > sei_pkg::CurVersion) begin
                    st = sei_pkg::ST_BAD_VERSION;
                end else if (34'(seen_count) != want_len) begin
                    st = sei_pkg::ST_SIZE;
                end else begin
                    r.store_size = ssize;
                    r.plugin_size = psize;
                    r.needs_plugin_restore = (psize != 0);
                    r.may_need_relink = (psize != 0);
                    tail = {tail_line[3], tail_line[2], tail_line[1], tail_line[0]};
                    if (tail != ~crc_acc) st = sei_pkg::ST_CRC;
                    else if (ssize == 0) st = sei_pkg::ST_EMPTY_STORE;
                    else if (r.needs_migration && !zero_mig_ready) st = sei_pkg::ST_NO_MIGRATE;
                    else st = budget_check(seen_count, ssize, psize);
                end
            end
        end
        r.status = st;
        return r;
    endfunction

    // Advances the predicted stream by one accepted item; returns 1 with a report when one is due.
    function automatic bit inspect_byte(input sei_pkg::t_in_item it,
                                        output sei_pkg::t_out_item r);
        r = '0;
        if (it.blob_empty) begin
            r.status = sei_pkg::ST_EMPTY;
            clear_blob();
            return 1'b1;
        end
        if (seen_count >= sei_pkg::FtrLen) crc_acc = crc_fold(crc_acc, tail_line[0]);
        tail_line[0] = tail_line[1];
        tail_line[1] = tail_line[2];
        tail_line[2] = tail_line[3];
        tail_line[3] = it.data_byte;
        if (seen_count < sei_pkg::HdrLen) seen_header[seen_count[3:0]] = it.data_byte;
        if (seen_count != 32'hFFFF_FFFF) seen_count++;
        if (!it.last_byte) return 1'b0;
        r = diagnose_blob();
        clear_blob();
        return 1'b1;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_count);
    endtask

    // Result checking: each accepted report is compared with the oldest prediction.
    always @(posedge i_clk) begin
        sei_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                note_mismatch("unexpected report, status", '0, 32'(o_out_item.status));
            end else begin
                want = expected_reports.pop_front();
                if (o_out_item.status != want.status)
                    note_mismatch("status", 32'(want.status), 32'(o_out_item.status));
                if (o_out_item.format != want.format)
                    note_mismatch("format", 32'(want.format), 32'(o_out_item.format));
                if (o_out_item.total_len != want.total_len)
                    note_mismatch("total_len", want.total_len, o_out_item.total_len);
                if (o_out_item.store_size != want.store_size)
                    note_mismatch("store_size", want.store_size, o_out_item.store_size);
                if (o_out_item.plugin_size != want.plugin_size)
                    note_mismatch("plugin_size", want.plugin_size, o_out_item.plugin_size);
                if (o_out_item.version_seen != want.version_seen)
                    note_mismatch("version_seen", want.version_seen, o_out_item.version_seen);
                if (o_out_item.needs_migration != want.needs_migration)
                    note_mismatch("needs_migration", 32'(want.needs_migration),
                                  32'(o_out_item.needs_migration));
                if (o_out_item.large_blob != want.large_blob)
                    note_mismatch("large_blob", 32'(want.large_blob),
                                  32'(o_out_item.large_blob));
                if (o_out_item.needs_plugin_restore != want.needs_plugin_restore)
                    note_mismatch("needs_plugin_restore", 32'(want.needs_plugin_restore),
                                  32'(o_out_item.needs_plugin_restore));
                if (o_out_item.may_need_relink != want.may_need_relink)
                    note_mismatch("may_need_relink", 32'(want.may_need_relink),
                                  32'(o_out_item.may_need_relink));
            end
        end
    end

    // Receiver stall: random runs, or one long hold-off when requested.
    initial begin
        int unsigned run;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                run = gap_len() + 1;
                i_out_stall <= ($urandom_range(0, 99) < 30);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input sei_pkg::t_in_item it);
        int unsigned        g;
        sei_pkg::t_out_item r;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (inspect_byte(it, r)) expected_reports = {expected_reports, r};
        bytes_sent++;
    endtask

    task automatic send_blob();
        blobs_sent++;
        while (blob_items.size() > 0) send_item(blob_items.pop_front());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Leaves the write valid high; the caller drops it after its last write.
    task automatic write_reg(input sei_pkg::t_cfg_index idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sei_pkg::CFG_MAX_TOTAL:  budget_total = value;
            sei_pkg::CFG_MAX_STORE:  budget_store = value;
            sei_pkg::CFG_MAX_PLUGIN: budget_plugin = value;
            sei_pkg::CFG_LARGE_THR:  large_limit = value;
            sei_pkg::CFG_MIG_READY:  zero_mig_ready = value[0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(8, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        sei_pkg::t_in_item it;
        it.data_byte = b;
        it.last_byte = 1'b0;
        it.blob_empty = 1'b0;
        blob_items = {blob_items, it};
    endfunction

    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
    endfunction

    // Builds one blob of the given kind into blob_items, closing item included.
    function automatic void build_blob(input t_blob_kind kind, input int unsigned slen,
                                       input int unsigned plen, input logic [31:0] ver);
        logic [31:0]       c;
        sei_pkg::t_in_item it;
        int unsigned       n;
        blob_items.delete();
        case (kind)
            BK_LEGACY: begin
                push_word(sei_pkg::MagicLegacy);
                for (int i = 0; i < slen; i++) push_byte(8'($urandom));
            end
            BK_ENV, BK_BAD_CRC, BK_SIZE: begin
                push_word(sei_pkg::MagicEnv);
                push_word(ver);
                push_word(slen);
                push_word(plen);
                for (int i = 0; i < slen + plen; i++) push_byte(8'($urandom));
                if (kind == BK_SIZE) push_byte(8'($urandom));
                c = sei_pkg::CrcInit;
                foreach (blob_items[i]) c = crc_fold(c, blob_items[i].data_byte);
                c = ~c;
                if (kind == BK_BAD_CRC) c[$urandom_range(0, 31)] ^= 1'b1;
                push_word(c);
            end
            BK_TRUNC: begin
                push_word(sei_pkg::MagicEnv);
                n = $urandom_range(0, 15);
                for (int i = 0; i < n; i++) push_byte(8'($urandom));
            end
            BK_NOISE, BK_EMPTY_MID, BK_BOTH: begin
                n = (kind == BK_NOISE) ? $urandom_range(1, 24) : $urandom_range(0, 6);
                for (int i = 0; i < n; i++) push_byte(8'($urandom));
            end
            default: ;
        endcase
        if (kind == BK_EMPTY || kind == BK_EMPTY_MID || kind == BK_BOTH) begin
            it.data_byte = 8'($urandom);
            it.last_byte = (kind == BK_BOTH) ? 1'b1 : 1'(($urandom & 1));
            it.blob_empty = 1'b1;
            blob_items = {blob_items, it};
        end else begin
            blob_items[blob_items.size() - 1].last_byte = 1'b1;
        end
    endfunction

    task automatic random_blob();
        int unsigned pick;
        logic [31:0] ver;
        pick = $urandom_range(0, 99);
        ver = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1;
        if (pick < 62)
            build_blob(BK_ENV, $urandom_range(0, 12), $urandom_range(0, 8), ver);
        else if (pick < 70) build_blob(BK_LEGACY, $urandom_range(0, 20), 0, 0);
        else if (pick < 76) build_blob(BK_BAD_CRC, $urandom_range(1, 8), $urandom_range(0, 4), ver);
        else if (pick < 80) build_blob(BK_SIZE, $urandom_range(0, 8), $urandom_range(0, 4), ver);
        else if (pick < 84) build_blob(BK_ENV, 2, 1, $urandom | 32'h2);
        else if (pick < 88) build_blob(BK_TRUNC, 0, 0, 0);
        else if (pick < 93) build_blob(BK_NOISE, 0, 0, 0);
        else if (pick < 96) build_blob(BK_EMPTY, 0, 0, 0);
        else if (pick < 98) build_blob(BK_EMPTY_MID, 0, 0, 0);
        else build_blob(BK_BOTH, 0, 0, 0);
        send_blob();
    endtask

    t_directed_row directed_rows [] = '{
        '{BK_EMPTY,     0, 0, 32'd0,          1'b1, sei_pkg::ST_EMPTY},
        '{BK_LEGACY,    0, 0, 32'd0,          1'b1, sei_pkg::ST_OK},
        '{BK_LEGACY,    9, 0, 32'd0,          1'b1, sei_pkg::ST_OK},
        '{BK_ENV,       3, 0, 32'd1,          1'b1, sei_pkg::ST_OK},
        '{BK_ENV,       1, 5, 32'd1,          1'b1, sei_pkg::ST_OK},
        '{BK_ENV,       4, 2, 32'd0,          1'b1, sei_pkg::ST_NO_MIGRATE},
        '{BK_ENV,       2, 0, 32'd2,          1'b1, sei_pkg::ST_BAD_VERSION},
        '{BK_ENV,       2, 0, 32'hFFFF_FFFF,  1'b1, sei_pkg::ST_BAD_VERSION},
        '{BK_ENV,       0, 3, 32'd1,          1'b1, sei_pkg::ST_EMPTY_STORE},
        '{BK_BAD_CRC,   5, 1, 32'd1,          1'b1, sei_pkg::ST_CRC},
        '{BK_SIZE,      5, 1, 32'd1,          1'b1, sei_pkg::ST_SIZE},
        '{BK_ENV,       8, 8, 32'h8000_0001,  1'b1, sei_pkg::ST_BAD_VERSION},
        '{BK_TRUNC,     0, 0, 32'd0,          1'b1, sei_pkg::ST_TRUNCATED},
        '{BK_NOISE,     0, 0, 32'd0,          1'b0, sei_pkg::ST_OK},
        '{BK_EMPTY_MID, 0, 0, 32'd0,          1'b1, sei_pkg::ST_EMPTY},
        '{BK_BOTH,      0, 0, 32'd0,          1'b1, sei_pkg::ST_EMPTY},
        '{BK_ENV,      16, 7, 32'd1,          1'b1, sei_pkg::ST_OK}
    };

    initial begin
        sei_pkg::t_out_item head;
        int unsigned        phase_goal;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = sei_pkg::CFG_MAX_TOTAL;
        i_cfg_data = '0;
        mismatches = 0;
        bytes_sent = 0;
        blobs_sent = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        budget_total = '0;
        budget_store = '0;
        budget_plugin = '0;
        large_limit = '0;
        zero_mig_ready = 1'b0;
        clear_blob();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blobs at reset configuration; statuses that are obvious are pinned here.
        foreach (directed_rows[i]) begin
            build_blob(directed_rows[i].kind, directed_rows[i].store_len,
                       directed_rows[i].plugin_len, directed_rows[i].version);
            send_blob();
            head = expected_reports[expected_reports.size() - 1];
            if (directed_rows[i].has_status && head.status != directed_rows[i].status)
                note_mismatch("directed row status", 32'(directed_rows[i].status),
                              32'(head.status));
        end
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                write_reg(sei_pkg::CFG_MAX_TOTAL, 32'hFFFF_FFFF);
                write_reg(sei_pkg::CFG_MAX_STORE, 32'hFFFF_FFFF);
                write_reg(sei_pkg::CFG_MAX_PLUGIN, 32'hFFFF_FFFF);
                write_reg(sei_pkg::CFG_LARGE_THR, 32'hFFFF_FFFF);
                write_reg(sei_pkg::CFG_MIG_READY, 32'd1);
            end else if (phase == 1) begin
                write_reg(sei_pkg::CFG_MAX_TOTAL, 32'd30);
                write_reg(sei_pkg::CFG_MAX_STORE, 32'd6);
                write_reg(sei_pkg::CFG_MAX_PLUGIN, 32'd3);
                write_reg(sei_pkg::CFG_LARGE_THR, 32'd20);
                write_reg(sei_pkg::CFG_MIG_READY, 32'd0);
            end else begin
                write_reg(sei_pkg::CFG_MAX_TOTAL, pick_limit());
                write_reg(sei_pkg::CFG_MAX_STORE,
                          ($urandom & 1) ? $urandom_range(1, 10) : pick_limit());
                write_reg(sei_pkg::CFG_MAX_PLUGIN,
                          ($urandom & 1) ? $urandom_range(1, 6) : pick_limit());
                write_reg(sei_pkg::CFG_LARGE_THR, pick_limit());
                write_reg(sei_pkg::CFG_MIG_READY, $urandom & 1);
            end
            i_cfg_valid <= 1'b0;
            no_idle = (phase == 3);
            if (phase == 2) begin
                // The receiver holds off while short blobs keep arriving, so the input backs up.
                hold_request = 1'b1;
                for (int k = 0; k < 8; k++) begin
                    build_blob(BK_NOISE, 0, 0, 0);
                    send_blob();
                end
            end
            phase_goal = 380 + 72 * (phase + 1);
            while (bytes_sent < phase_goal) random_blob();
            drain();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/sei_pkg.sv
design/sei_front.sv
design/sei_queue.sv
design/sei_back.sv
design/state_envelope_inspector.sv
verif/state_envelope_inspector_tb.sv
